@@ rtl/tvs_pkg.sv @@
// Shared types, constants and waveform/envelope helper functions of the sound generator.
package tvs_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
  } item_t;

  localparam logic [1:0] REQ_READ     = 2'd0;
  localparam logic [1:0] REQ_WRITE    = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam int NumRegs = 25;
  localparam int NumVoices = 3;

  localparam logic [4:0] ADDR_VOLUME = 5'd24;
  localparam logic [4:0] ADDR_POT_X  = 5'd25;
  localparam logic [4:0] ADDR_POT_Y  = 5'd26;
  localparam logic [4:0] ADDR_OSC3   = 5'd27;
  localparam logic [4:0] ADDR_ENV3   = 5'd28;

  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_DECAY   = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;

  // The scaled mix is mix * volume * 4681 / 6712875, taken as a product with a
  // rounded-up constant 4681 * 2^49 / 6712875 that is exact over the whole input range.
  localparam logic [38:0] MIX_RECIP = 39'(((64'd4681 << 49) / 64'd6712875) + 64'd1);
  localparam logic [18:0] MIX_RECIP_HI = MIX_RECIP[38:20];
  localparam logic [19:0] MIX_RECIP_LO = MIX_RECIP[19:0];

  function automatic logic [14:0] rate_period(input logic [3:0] rate);
    logic [14:0] p;
    unique case (rate)
      4'd0:  p = 15'd9;
      4'd1:  p = 15'd32;
      4'd2:  p = 15'd63;
      4'd3:  p = 15'd95;
      4'd4:  p = 15'd149;
      4'd5:  p = 15'd220;
      4'd6:  p = 15'd267;
      4'd7:  p = 15'd313;
      4'd8:  p = 15'd392;
      4'd9:  p = 15'd977;
      4'd10: p = 15'd1954;
      4'd11: p = 15'd3126;
      4'd12: p = 15'd3906;
      4'd13: p = 15'd11720;
      4'd14: p = 15'd19531;
      default: p = 15'd31251;
    endcase
    return p;
  endfunction

  function automatic logic [4:0] exp_divisor(input logic [7:0] lvl);
    logic [4:0] d;
    priority if (lvl > 8'd93) d = 5'd1;
    else if (lvl > 8'd53) d = 5'd2;
    else if (lvl > 8'd25) d = 5'd4;
    else if (lvl > 8'd13) d = 5'd8;
    else if (lvl > 8'd5) d = 5'd16;
    else d = 5'd30;
    return d;
  endfunction

  function automatic logic [11:0] voice_wave(input logic [7:0] ctl, input logic [23:0] acc,
                                             input logic src_msb, input logic [11:0] pw,
                                             input logic [22:0] noise);
    logic [11:0] w;
    logic [23:0] t;
    logic msb;
    logic any;
    w = 12'hFFF;
    any = 1'b0;
    msb = ctl[2] ? src_msb : acc[23];
    t = msb ? ~acc : acc;
    if (ctl[5]) begin
      w = w & acc[23:12];
      any = 1'b1;
    end
    if (ctl[4]) begin
      w = w & t[22:11];
      any = 1'b1;
    end
    if (ctl[6]) begin
      w = w & ((acc[23:12] >= pw) ? 12'hFFF : 12'h000);
      any = 1'b1;
    end
    if (ctl[7]) begin
      w = w & {noise[22:15], 4'b0000};
      any = 1'b1;
    end
    return any ? w : 12'h000;
  endfunction

endpackage

@@ rtl/three_voice_sound_synth.sv @@
// Each accepted word is fetched from the input queue and executed, then the three voices are
// mixed in turn and the mix is scaled by volume with a reciprocal product before the result word
// is offered; the core takes a new word only after the last result word has been taken.
// The input queue keeps accepting words while it has room, as the core works or waits on out_ready.
// Synchronous active-high reset clears the register file, accumulators and envelopes;
// noise registers reset to all ones and envelopes to release.
module three_voice_sound_synth #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [4:0]  reg_addr,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [14:0] audio_sample
);

  tvs_pkg::item_t in_item;
  tvs_pkg::item_t q_item;
  logic q_valid;
  logic q_pop;

  assign in_item.req_type = req_type;
  assign in_item.reg_addr = reg_addr;
  assign in_item.write_data = write_data;

  tvs_front #(.Depth(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tvs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .audio_sample (audio_sample)
  );

endmodule

@@ rtl/tvs_front.sv @@
// Input queue that accepts request words and holds them for the execution core.
module tvs_front #(
  parameter int Depth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tvs_pkg::item_t      in_item,
  output logic                q_valid,
  output tvs_pkg::item_t      q_item,
  input  logic                q_pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tvs_pkg::item_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != CntW'(Depth));
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tvs_core.sv @@
// Execution core: register file, oscillators, envelopes, mixer and output scaling.
module tvs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  tvs_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_data,
  output logic [14:0]    audio_sample
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_MIX   = 6'b000100,
    S_SCALE = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  tvs_pkg::item_t cur;

  logic [7:0]  regs  [tvs_pkg::NumRegs];
  logic [23:0] acc   [tvs_pkg::NumVoices];
  logic [22:0] noise [tvs_pkg::NumVoices];
  logic [7:0]  lvl   [tvs_pkg::NumVoices];
  logic [1:0]  ph    [tvs_pkg::NumVoices];
  logic [14:0] rc    [tvs_pkg::NumVoices];
  logic [4:0]  ec    [tvs_pkg::NumVoices];
  logic        gate  [tvs_pkg::NumVoices];

  logic [23:0] acc_add   [tvs_pkg::NumVoices];
  logic [23:0] acc_next  [tvs_pkg::NumVoices];
  logic [22:0] noise_next [tvs_pkg::NumVoices];
  logic [7:0]  lvl_next  [tvs_pkg::NumVoices];
  logic [1:0]  ph_next   [tvs_pkg::NumVoices];
  logic [14:0] rc_next   [tvs_pkg::NumVoices];
  logic [4:0]  ec_next   [tvs_pkg::NumVoices];

  logic [1:0]  vc;
  logic [21:0] mix;
  logic        step;
  logic [7:0]  rd_value;
  logic [11:0] mix_wave;
  logic [7:0]  mix_lvl;
  logic [19:0] mix_prod;
  logic [25:0] scaled_x;
  logic [25:0] scaled_x_next;
  logic [44:0] prod_hi;
  logic [45:0] prod_lo;
  logic [44:0] prod_hi_next;
  logic [45:0] prod_lo_next;
  logic [45:0] recip_sum;

  always_comb begin
    for (int v = 0; v < tvs_pkg::NumVoices; v++) begin
      acc_add[v] = regs[v*7+4][3] ? 24'd0 : acc[v] + {8'd0, regs[v*7+1], regs[v*7]};
    end
    acc_next[0] = (regs[4][1] && !acc[2][23] && acc_add[2][23]) ? 24'd0 : acc_add[0];
    acc_next[1] = (regs[11][1] && !acc[0][23] && acc_next[0][23]) ? 24'd0 : acc_add[1];
    acc_next[2] = (regs[18][1] && !acc[1][23] && acc_next[1][23]) ? 24'd0 : acc_add[2];
    for (int v = 0; v < tvs_pkg::NumVoices; v++) begin
      if (regs[v*7+4][3]) begin
        noise_next[v] = 23'h7FFFFF;
      end else if (!acc[v][19] && acc_next[v][19]) begin
        noise_next[v] = {noise[v][21:0], noise[v][22] ^ noise[v][17]};
      end else begin
        noise_next[v] = noise[v];
      end
    end
  end

  always_comb begin
    logic [3:0]  rate  [tvs_pkg::NumVoices];
    logic [7:0]  sus   [tvs_pkg::NumVoices];
    logic [14:0] rcinc [tvs_pkg::NumVoices];
    logic [4:0]  ecinc [tvs_pkg::NumVoices];
    for (int v = 0; v < tvs_pkg::NumVoices; v++) begin
      if (ph[v] == tvs_pkg::PH_ATTACK) begin
        rate[v] = regs[v*7+5][7:4];
      end else if (ph[v] == tvs_pkg::PH_DECAY) begin
        rate[v] = regs[v*7+5][3:0];
      end else begin
        rate[v] = regs[v*7+6][3:0];
      end
      sus[v] = {regs[v*7+6][7:4], regs[v*7+6][7:4]};
      rcinc[v] = rc[v] + 1'b1;
      ecinc[v] = ec[v] + 1'b1;
      lvl_next[v] = lvl[v];
      ph_next[v] = ph[v];
      ec_next[v] = ec[v];
      rc_next[v] = rcinc[v];
      if (rcinc[v] >= tvs_pkg::rate_period(rate[v])) begin
        rc_next[v] = '0;
        if (ph[v] == tvs_pkg::PH_ATTACK) begin
          if (lvl[v] != 8'hFF) begin
            lvl_next[v] = lvl[v] + 1'b1;
          end
          if (lvl_next[v] == 8'hFF) begin
            ph_next[v] = tvs_pkg::PH_DECAY;
          end
        end else if (ecinc[v] < tvs_pkg::exp_divisor(lvl[v])) begin
          ec_next[v] = ecinc[v];
        end else begin
          ec_next[v] = '0;
          if (ph[v] == tvs_pkg::PH_DECAY) begin
            if (lvl[v] > sus[v]) begin
              lvl_next[v] = lvl[v] - 1'b1;
            end
          end else if (lvl[v] != 8'd0) begin
            lvl_next[v] = lvl[v] - 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    logic [11:0] osc3;
    osc3 = tvs_pkg::voice_wave(regs[18], acc[2], acc[1][23], {regs[17][3:0], regs[16]}, noise[2]);
    rd_value = 8'd0;
    if (cur.req_type == tvs_pkg::REQ_READ) begin
      priority if (cur.reg_addr == tvs_pkg::ADDR_POT_X || cur.reg_addr == tvs_pkg::ADDR_POT_Y) begin
        rd_value = 8'hFF;
      end else if (cur.reg_addr == tvs_pkg::ADDR_OSC3) begin
        rd_value = osc3[11:4];
      end else if (cur.reg_addr == tvs_pkg::ADDR_ENV3) begin
        rd_value = lvl[2];
      end else if (cur.reg_addr > tvs_pkg::ADDR_ENV3) begin
        rd_value = 8'd0;
      end else begin
        rd_value = regs[cur.reg_addr];
      end
    end
  end

  always_comb begin
    unique case (vc)
      2'd0: begin
        mix_wave = tvs_pkg::voice_wave(regs[4], acc[0], acc[2][23], {regs[3][3:0], regs[2]},
                                       noise[0]);
        mix_lvl = lvl[0];
      end
      2'd1: begin
        mix_wave = tvs_pkg::voice_wave(regs[11], acc[1], acc[0][23], {regs[10][3:0], regs[9]},
                                       noise[1]);
        mix_lvl = lvl[1];
      end
      default: begin
        mix_wave = tvs_pkg::voice_wave(regs[18], acc[2], acc[1][23], {regs[17][3:0], regs[16]},
                                       noise[2]);
        mix_lvl = (regs[tvs_pkg::ADDR_VOLUME][7]) ? 8'd0 : lvl[2];
      end
    endcase
    mix_prod = mix_wave * mix_lvl;
    scaled_x_next = mix * regs[tvs_pkg::ADDR_VOLUME][3:0];
    prod_hi_next = scaled_x * tvs_pkg::MIX_RECIP_HI;
    prod_lo_next = scaled_x * tvs_pkg::MIX_RECIP_LO;
    recip_sum = {1'b0, prod_hi} + {20'd0, prod_lo[45:20]};
  end

  assign q_pop = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < tvs_pkg::NumRegs; i++) begin
        regs[i] <= 8'd0;
      end
      for (int v = 0; v < tvs_pkg::NumVoices; v++) begin
        acc[v] <= '0;
        noise[v] <= 23'h7FFFFF;
        lvl[v] <= '0;
        ph[v] <= tvs_pkg::PH_RELEASE;
        rc[v] <= '0;
        ec[v] <= '0;
        gate[v] <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          read_data <= rd_value;
          if (cur.req_type == tvs_pkg::REQ_WRITE && cur.reg_addr <= tvs_pkg::ADDR_VOLUME) begin
            regs[cur.reg_addr] <= cur.write_data;
            for (int v = 0; v < tvs_pkg::NumVoices; v++) begin
              if (cur.reg_addr == 5'(v*7+4)) begin
                if (cur.write_data[0] && !gate[v]) begin
                  ph[v] <= tvs_pkg::PH_ATTACK;
                end else if (!cur.write_data[0] && gate[v]) begin
                  ph[v] <= tvs_pkg::PH_RELEASE;
                end
                gate[v] <= cur.write_data[0];
                if (cur.write_data[3]) begin
                  acc[v] <= '0;
                  noise[v] <= 23'h7FFFFF;
                end
              end
            end
          end else if (cur.req_type == tvs_pkg::REQ_TICK) begin
            for (int v = 0; v < tvs_pkg::NumVoices; v++) begin
              acc[v] <= acc_next[v];
              noise[v] <= noise_next[v];
              lvl[v] <= lvl_next[v];
              ph[v] <= ph_next[v];
              rc[v] <= rc_next[v];
              ec[v] <= ec_next[v];
            end
          end
          vc <= 2'd0;
          mix <= '0;
          state <= S_MIX;
        end
        S_MIX: begin
          mix <= mix + {2'd0, mix_prod};
          vc <= vc + 1'b1;
          if (vc == 2'd2) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          scaled_x <= scaled_x_next;
          step <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!step) begin
            prod_hi <= prod_hi_next;
            prod_lo <= prod_lo_next;
            step <= 1'b1;
          end else begin
            audio_sample <= recip_sum[43:29];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/tvs_checker.sv @@
// Port-level checker for the sound generator and its bind statement.
module tvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  read_data,
  input logic [14:0] audio_sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result word dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_data) && $stable(audio_sample))
    else $error("Result word changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Block not empty after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("Back-to-back results from the serial core.");

endmodule

bind three_voice_sound_synth tvs_checker u_tvs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .audio_sample (audio_sample)
);
